// File: design/bdq_pkg.sv
// Shared constants, types and index arithmetic for the bounded deque with search.
package bdq_pkg;

  localparam int unsigned DEPTH   = 64;
  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned COUNT_W = 7;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;
  localparam logic [OP_W-1:0] OP_LENGTH     = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Ring index arithmetic: base is below DEPTH and offset at most DEPTH,
  // so a single conditional subtract brings the sum back into range.
  function automatic idx_t wrap_add(idx_t base, cnt_t offset);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offset);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return IDX_W'(sum);
  endfunction

endpackage

// File: design/bdq_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/bounded_deque_with_search_unit.sv
// Bounded deque of signed 32-bit values in a ring-buffer RAM with a linear search.
//
// Each input transaction carries one operation; exactly one result transaction follows.
// Pushes, length queries, the unused codes, and operations refused as full or empty
// finish in the accepting cycle and their result is registered at that edge. A pop
// reads the entry RAM once; its result is registered in the following cycle. A search
// streams one RAM read per cycle from the front of the queue and compares each
// returned entry with the key; a hit produces the result at the first matching
// entry from the front, and a miss once the back entry has been compared.
// The single RAM read port sets the search rate. A new transaction is accepted
// only while no other is in progress and the result register is empty or being
// drained in the same cycle. The RAM needs no clearing after reset: only
// occupied entries are ever read.
module bounded_deque_with_search_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bdq_pkg::OP_W-1:0]            in_op,
  input  logic signed [bdq_pkg::DATA_W-1:0]   in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bdq_pkg::STAT_W-1:0]          out_status,
  output logic signed [bdq_pkg::DATA_W-1:0]   out_data,
  output logic [bdq_pkg::COUNT_W-1:0]         out_count
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_SRCH = 3'b100
  } state_t;

  state_t                             state_r, state_nxt;
  bdq_pkg::idx_t                      head_r, head_nxt;
  bdq_pkg::cnt_t                      count_r, count_nxt;
  bdq_pkg::cnt_t                      sidx_r, sidx_nxt;
  logic                               cmp_valid_r, cmp_valid_nxt;
  logic                               last_r, last_nxt;
  logic [bdq_pkg::DATA_W-1:0]         key_r, key_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic [bdq_pkg::STAT_W-1:0]         out_status_r, out_status_nxt;
  logic [bdq_pkg::DATA_W-1:0]         out_data_r, out_data_nxt;
  logic [bdq_pkg::COUNT_W-1:0]        out_count_r, out_count_nxt;

  logic                               accept;
  logic                               is_full;
  logic                               is_empty;
  logic                               ram_we;
  logic                               ram_re;
  bdq_pkg::idx_t                      ram_waddr;
  bdq_pkg::idx_t                      ram_raddr;
  logic [bdq_pkg::DATA_W-1:0]         ram_rdata;
  bdq_pkg::idx_t                      front_idx;

  assign in_ready   = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept     = in_valid && in_ready;
  assign is_full    = (count_r == bdq_pkg::cnt_t'(bdq_pkg::DEPTH));
  assign is_empty   = (count_r == '0);
  assign front_idx  = bdq_pkg::wrap_add(head_r, bdq_pkg::cnt_t'(bdq_pkg::DEPTH - 1));

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_count  = out_count_r;

  bdq_ram #(
    .WIDTH (bdq_pkg::DATA_W),
    .DEPTH (bdq_pkg::DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    sidx_nxt       = sidx_r;
    cmp_valid_nxt  = 1'b0;
    last_nxt       = last_r;
    key_nxt        = key_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = head_r;
    ram_raddr      = head_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_status_nxt = bdq_pkg::ST_OK;
          out_data_nxt   = '0;
          out_count_nxt  = bdq_pkg::COUNT_W'(count_r);
          out_valid_nxt  = 1'b1;
          case (in_op)
            bdq_pkg::OP_PUSH_BACK: begin
              if (is_full) begin
                out_status_nxt = bdq_pkg::ST_FULL;
              end else begin
                ram_we        = 1'b1;
                ram_waddr     = bdq_pkg::wrap_add(head_r, count_r);
                count_nxt     = count_r + 1'b1;
                out_count_nxt = bdq_pkg::COUNT_W'(count_nxt);
              end
            end
            bdq_pkg::OP_PUSH_FRONT: begin
              if (is_full) begin
                out_status_nxt = bdq_pkg::ST_FULL;
              end else begin
                ram_we        = 1'b1;
                ram_waddr     = front_idx;
                head_nxt      = front_idx;
                count_nxt     = count_r + 1'b1;
                out_count_nxt = bdq_pkg::COUNT_W'(count_nxt);
              end
            end
            bdq_pkg::OP_POP_BACK: begin
              if (is_empty) begin
                out_status_nxt = bdq_pkg::ST_EMPTY;
              end else begin
                ram_re        = 1'b1;
                ram_raddr     = bdq_pkg::wrap_add(head_r, count_r - 1'b1);
                count_nxt     = count_r - 1'b1;
                out_valid_nxt = 1'b0;
                state_nxt     = S_POP;
              end
            end
            bdq_pkg::OP_POP_FRONT: begin
              if (is_empty) begin
                out_status_nxt = bdq_pkg::ST_EMPTY;
              end else begin
                ram_re        = 1'b1;
                ram_raddr     = head_r;
                head_nxt      = bdq_pkg::wrap_add(head_r, bdq_pkg::cnt_t'(1));
                count_nxt     = count_r - 1'b1;
                out_valid_nxt = 1'b0;
                state_nxt     = S_POP;
              end
            end
            bdq_pkg::OP_SEARCH: begin
              if (is_empty) begin
                out_status_nxt = bdq_pkg::ST_EMPTY;
              end else begin
                key_nxt       = in_value;
                sidx_nxt      = '0;
                last_nxt      = 1'b0;
                out_valid_nxt = 1'b0;
                state_nxt     = S_SRCH;
              end
            end
            default: begin
              // Length and the unused codes leave the state alone.
            end
          endcase
        end
      end

      S_POP: begin
        // The entry read at acceptance is on the RAM output now.
        out_valid_nxt  = 1'b1;
        out_status_nxt = bdq_pkg::ST_OK;
        out_data_nxt   = ram_rdata;
        out_count_nxt  = bdq_pkg::COUNT_W'(count_r);
        state_nxt      = S_IDLE;
      end

      S_SRCH: begin
        // Reads are issued one per cycle; each compare sees the read of the
        // previous cycle, tagged as the last one when it held the back entry.
        if (sidx_r != count_r) begin
          ram_re        = 1'b1;
          ram_raddr     = bdq_pkg::wrap_add(head_r, sidx_r);
          sidx_nxt      = sidx_r + 1'b1;
          last_nxt      = (sidx_r == count_r - 1'b1);
          cmp_valid_nxt = 1'b1;
        end
        if (cmp_valid_r) begin
          if (ram_rdata == key_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = bdq_pkg::ST_FOUND;
            out_data_nxt   = '0;
            out_count_nxt  = bdq_pkg::COUNT_W'(count_r);
            cmp_valid_nxt  = 1'b0;
            state_nxt      = S_IDLE;
          end else if (last_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = bdq_pkg::ST_NOT_FOUND;
            out_data_nxt   = '0;
            out_count_nxt  = bdq_pkg::COUNT_W'(count_r);
            cmp_valid_nxt  = 1'b0;
            state_nxt      = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sidx_r       <= sidx_nxt;
    last_r       <= last_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

// File: sim/bdq_checker.sv
// Reply checker for the bounded deque: models the ring, predicts every reply and compares it.
`timescale 1ns / 1ps
module deque_reply_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [bdq_pkg::OP_W-1:0]          in_op,
  input  logic signed [bdq_pkg::DATA_W-1:0] in_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [bdq_pkg::STAT_W-1:0]        out_status,
  input  logic signed [bdq_pkg::DATA_W-1:0] out_data,
  input  logic [bdq_pkg::COUNT_W-1:0]       out_count,
  output int                                mismatch_count,
  output int                                replies_due,
  output int                                replies_checked,
  output int                                full_refusals,
  output int                                empty_replies,
  output int                                search_hits,
  output int                                search_misses
);
  import bdq_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data;
    logic [COUNT_W-1:0]       count;
  } deque_reply_t;

  // Shadow copy of the deque: ring cells, front position and fill level.
  logic signed [DATA_W-1:0] ring_cells [DEPTH];
  int unsigned              front_idx;
  int unsigned              fill_count;
  deque_reply_t             replies_in_flight [$];

  // Applies one request to the shadow deque and returns the reply it must produce.
  function automatic deque_reply_t deque_reply_for(logic [OP_W-1:0] op,
                                                   logic signed [DATA_W-1:0] key);
    deque_reply_t reply;
    int unsigned  pos;
    bit           hit;
    reply.status = ST_OK;
    reply.data   = '0;
    case (op)
      OP_PUSH_BACK: begin
        if (fill_count == DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          ring_cells[(front_idx + fill_count) % DEPTH] = key;
          fill_count++;
        end
      end
      OP_PUSH_FRONT: begin
        if (fill_count == DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          front_idx = (front_idx + DEPTH - 1) % DEPTH;
          ring_cells[front_idx] = key;
          fill_count++;
        end
      end
      OP_POP_BACK: begin
        if (fill_count == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          reply.data = ring_cells[(front_idx + fill_count - 1) % DEPTH];
          fill_count--;
        end
      end
      OP_POP_FRONT: begin
        if (fill_count == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          reply.data = ring_cells[front_idx];
          front_idx  = (front_idx + 1) % DEPTH;
          fill_count--;
        end
      end
      OP_SEARCH: begin
        if (fill_count == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          hit = 1'b0;
          for (pos = 0; pos < fill_count; pos++) begin
            if (ring_cells[(front_idx + pos) % DEPTH] == key) begin
              hit = 1'b1;
            end
          end
          reply.status = hit ? ST_FOUND : ST_NOT_FOUND;
        end
      end
      // Length and the two spare codes leave the deque alone.
      default: begin
      end
    endcase
    reply.count = COUNT_W'(fill_count);
    return reply;
  endfunction

  // The reply taken at an edge always belongs to an earlier request, so it is
  // checked before the request accepted at the same edge is applied.
  always @(posedge clk) begin
    deque_reply_t want;
    if (!rst_n) begin
      front_idx       = 0;
      fill_count      = 0;
      replies_in_flight.delete();
      mismatch_count  = 0;
      replies_due     = 0;
      replies_checked = 0;
      full_refusals   = 0;
      empty_replies   = 0;
      search_hits     = 0;
      search_misses   = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (replies_in_flight.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("MISMATCH at %0t: reply with nothing outstanding: status %0d data %0d count %0d",
                     $realtime, out_status, out_data, out_count);
          end
          mismatch_count++;
        end else begin
          want = replies_in_flight.pop_front();
          if (out_status !== want.status || out_data !== want.data ||
              out_count !== want.count) begin
            if (mismatch_count < 10) begin
              $display("MISMATCH at %0t: status %0d/%0d data %0d/%0d count %0d/%0d (want/got)",
                       $realtime, want.status, out_status, want.data, out_data,
                       want.count, out_count);
            end
            mismatch_count++;
          end
          replies_checked++;
          case (want.status)
            ST_FULL:      full_refusals++;
            ST_EMPTY:     empty_replies++;
            ST_FOUND:     search_hits++;
            ST_NOT_FOUND: search_misses++;
            default: begin
            end
          endcase
        end
      end
      if (in_valid && in_ready) begin
        replies_in_flight.push_back(deque_reply_for(in_op, in_value));
      end
      replies_due = replies_in_flight.size();
    end
  end

endmodule

// File: sim/tb_top.sv
// Testbench top for the bounded deque: clock, reset, request and reply traffic, verdict.
`timescale 1ns / 1ps
module tb_top;
  import bdq_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int ROUNDS           = 10;
  localparam int ROUND_ITEMS      = 100;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES      = 80;
  localparam int CYCLE_LIMIT      = 1000000;

  typedef enum logic [1:0] {ROUND_FILL, ROUND_MIX, ROUND_DRAIN} round_kind_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [OP_W-1:0]          in_op;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_ready;
  logic [STAT_W-1:0]        out_status;
  logic signed [DATA_W-1:0] out_data;
  logic [COUNT_W-1:0]       out_count;

  int mismatch_count;
  int replies_due;
  int replies_checked;
  int full_refusals;
  int empty_replies;
  int search_hits;
  int search_misses;

  bit                       sender_quiet;
  bit                       receiver_quiet;
  bit                       long_hold_req;
  int                       long_holds_done;
  int                       cycle_count;
  logic signed [DATA_W-1:0] value_pool [16];

  bounded_deque_with_search_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_data   (out_data),
    .out_count  (out_count)
  );

  deque_reply_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_data        (out_data),
    .out_count       (out_count),
    .mismatch_count  (mismatch_count),
    .replies_due     (replies_due),
    .replies_checked (replies_checked),
    .full_refusals   (full_refusals),
    .empty_replies   (empty_replies),
    .search_hits     (search_hits),
    .search_misses   (search_misses)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d replies outstanding", cycle_count, replies_due);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Offers one request after a random gap, none when quiet, and holds it until taken.
  task automatic send_request(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value);
    int unsigned gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= value;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Stops offering until every reply owed by the block has been taken.
  task automatic wait_replies_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (replies_due != 0) @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = value_pool[$urandom_range(0, 15)];
      3: begin
        case ($urandom_range(0, 3))
          0:       v = 32'sh7FFF_FFFF;
          1:       v = 32'sh8000_0000;
          2:       v = '0;
          default: v = -32'sd1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [OP_W-1:0] pick_op(round_kind_t kind);
    int unsigned roll;
    logic [OP_W-1:0] op;
    roll = $urandom_range(0, 99);
    case (kind)
      ROUND_FILL: begin
        if (roll < 42)      op = OP_PUSH_BACK;
        else if (roll < 84) op = OP_PUSH_FRONT;
        else if (roll < 94) op = OP_SEARCH;
        else if (roll < 96) op = OP_POP_BACK;
        else if (roll < 98) op = OP_POP_FRONT;
        else                op = OP_LENGTH;
      end
      ROUND_DRAIN: begin
        if (roll < 40)      op = OP_POP_BACK;
        else if (roll < 80) op = OP_POP_FRONT;
        else if (roll < 90) op = OP_SEARCH;
        else if (roll < 93) op = OP_PUSH_BACK;
        else if (roll < 96) op = OP_PUSH_FRONT;
        else                op = OP_LENGTH;
      end
      default: begin
        if (roll < 18)      op = OP_PUSH_BACK;
        else if (roll < 36) op = OP_PUSH_FRONT;
        else if (roll < 52) op = OP_POP_BACK;
        else if (roll < 68) op = OP_POP_FRONT;
        else if (roll < 93) op = OP_SEARCH;
        else if (roll < 97) op = OP_LENGTH;
        else if (roll < 98) op = OP_SPARE_6;
        else                op = OP_SPARE_7;
      end
    endcase
    return op;
  endfunction

  // Reply side: a random stall before each transaction, none in quiet rounds,
  // and a long hold-off when the stimulus asks for one.
  initial begin
    int unsigned gap;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      if (long_hold_req) begin
        gap = LONG_HOLD_CYCLES;
        long_hold_req = 1'b0;
        long_holds_done++;
      end else if (receiver_quiet) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 19);
      end
      if (gap != 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    int          r;
    int          k;
    round_kind_t kind;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = OP_LENGTH;
    in_value       = '0;
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    long_hold_req  = 1'b0;
    value_pool[0]  = 32'sh7FFF_FFFF;
    value_pool[1]  = 32'sh8000_0000;
    value_pool[2]  = '0;
    value_pool[3]  = -32'sd1;
    for (k = 4; k < 16; k++) begin
      value_pool[k] = $urandom;
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Empty deque: pops and search report empty, length and spare codes are no-ops.
    send_request(OP_POP_BACK, 32'sd17);
    send_request(OP_POP_FRONT, -32'sd17);
    send_request(OP_SEARCH, '0);
    send_request(OP_LENGTH, 32'sh5555_5555);
    send_request(OP_SPARE_6, 32'shAAAA_AAAA);
    send_request(OP_SPARE_7, -32'sd1);
    // Value extremes at both ends, then a hit and a miss.
    send_request(OP_PUSH_BACK, 32'sh7FFF_FFFF);
    send_request(OP_PUSH_FRONT, 32'sh8000_0000);
    send_request(OP_PUSH_BACK, '0);
    send_request(OP_PUSH_FRONT, -32'sd1);
    send_request(OP_SEARCH, 32'sh8000_0000);
    send_request(OP_SEARCH, 32'sh0001_2345);
    send_request(OP_LENGTH, '0);
    send_request(OP_SPARE_6, 32'sh7FFF_FFFF);
    send_request(OP_POP_FRONT, '0);
    send_request(OP_POP_BACK, '0);
    send_request(OP_POP_BACK, '0);
    // The last node leaves by the front; then a front push into the empty deque.
    send_request(OP_POP_FRONT, '0);
    send_request(OP_PUSH_FRONT, 32'sd5);
    send_request(OP_PUSH_BACK, 32'sd6);
    send_request(OP_POP_FRONT, '0);
    send_request(OP_POP_BACK, '0);
    send_request(OP_POP_BACK, '0);
    wait_replies_drained();

    // Rounds cycle through filling to full, mixed traffic near full, and draining to empty.
    for (r = 0; r < ROUNDS; r++) begin
      case (r % 3)
        0:       kind = ROUND_FILL;
        1:       kind = ROUND_MIX;
        default: kind = ROUND_DRAIN;
      endcase
      sender_quiet   = (r % 4 == 1);
      receiver_quiet = (r % 4 == 2);
      if (r == 2 || r == 7) begin
        long_hold_req = 1'b1;
      end
      for (k = 0; k < ROUND_ITEMS; k++) begin
        send_request(pick_op(kind), pick_value());
      end
      wait_replies_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Checked %0d replies: %0d refused as full, %0d empty, %0d search hits, %0d misses.",
             replies_checked, full_refusals, empty_replies, search_hits, search_misses);
    $display("Traffic went %0d times from empty to full and back, with %0d long reply stalls.",
             ROUNDS / 3, long_holds_done);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: sim.f
design/bdq_pkg.sv
design/bdq_ram.sv
design/bounded_deque_with_search_unit.sv
sim/bdq_checker.sv
sim/tb_top.sv
